// ===== hdl/id3tl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3v2 tag locator package
// Shared widths, codes, constants and types for the tag locator.
// ----------------------------------------------------------------------------
package id3tl_pkg;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int SIZE_W   = 29;
   localparam int PHASE_W  = 3;
   localparam int MATCH_W  = 2;

   localparam logic [PHASE_W-1:0] PH_SEARCH  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HEADER  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_COLLECT = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DONE    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_ENDED   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_SEARCH   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TAG      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LAST     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd5;

   localparam logic [MATCH_W-1:0] MATCH_NONE = 2'd0;
   localparam logic [MATCH_W-1:0] MATCH_I    = 2'd1;
   localparam logic [MATCH_W-1:0] MATCH_ID   = 2'd2;

   localparam logic [BYTE_W-1:0] CHAR_I     = 8'h49;
   localparam logic [BYTE_W-1:0] CHAR_D     = 8'h44;
   localparam logic [BYTE_W-1:0] CHAR_THREE = 8'h33;

   localparam logic [SIZE_W-1:0] ID_LEN     = 29'd3;
   localparam logic [SIZE_W-1:0] SIZE_FIRST = 29'd6;
   localparam logic [SIZE_W-1:0] HDR_LEN    = 29'd10;

   localparam int SYNCSAFE_W = 7;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [MATCH_W-1:0] match_progress;
      logic [SIZE_W-1:0]  tag_size;
      logic [SIZE_W-1:0]  bytes_taken;
   } tracker_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic [STATUS_W-1:0] status;
      logic [SIZE_W-1:0]   tag_total_size;
   } result_type;

endpackage

// ===== hdl/id3tl_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3v2 tag locator channels
// Valid/ready interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
interface id3tl_req_if;
   logic                            valid;
   logic                            ready;
   logic [id3tl_pkg::BYTE_W-1:0]    data_byte;
   logic                            end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface id3tl_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [id3tl_pkg::BYTE_W-1:0]    out_byte;
   logic [id3tl_pkg::STATUS_W-1:0]  status;
   logic [id3tl_pkg::SIZE_W-1:0]    tag_total_size;

   modport source (output valid, output out_byte, output status, output tag_total_size,
                   input ready);
   modport sink   (input valid, input out_byte, input status, input tag_total_size,
                   output ready);
endinterface

// ===== hdl/id3tl_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3v2 tag locator step logic
// Combinational next-state and result for one stream byte.
// ----------------------------------------------------------------------------
module id3tl_step (
   input  id3tl_pkg::tracker_type             cur,
   input  logic [id3tl_pkg::BYTE_W-1:0]       data_byte,
   input  logic                               end_of_stream,
   output id3tl_pkg::tracker_type             nxt,
   output id3tl_pkg::result_type              res
);

   logic [id3tl_pkg::SIZE_W-1:0] taken_inc;
   logic [id3tl_pkg::SIZE_W-1:0] size_shift;
   logic [id3tl_pkg::SIZE_W-1:0] size_hdr;
   logic [id3tl_pkg::SIZE_W-1:0] size_total;

   assign taken_inc  = cur.bytes_taken + 29'd1;
   assign size_shift = {cur.tag_size[id3tl_pkg::SIZE_W-id3tl_pkg::SYNCSAFE_W-1:0],
                        data_byte[id3tl_pkg::SYNCSAFE_W-1:0]};
   assign size_hdr   = (cur.bytes_taken >= id3tl_pkg::SIZE_FIRST) ? size_shift : cur.tag_size;
   assign size_total = size_hdr + id3tl_pkg::HDR_LEN;

   always_comb begin
      nxt          = cur;
      res.out_byte = '0;
      res.status   = id3tl_pkg::ST_IGNORED;
      unique case (cur.phase)
         id3tl_pkg::PH_SEARCH: begin
            res.out_byte = data_byte;
            res.status   = id3tl_pkg::ST_SEARCH;
            if (cur.match_progress == id3tl_pkg::MATCH_ID &&
                data_byte == id3tl_pkg::CHAR_THREE) begin
               nxt.match_progress = id3tl_pkg::MATCH_NONE;
               nxt.tag_size       = '0;
               nxt.bytes_taken    = id3tl_pkg::ID_LEN;
               nxt.phase          = id3tl_pkg::PH_HEADER;
               res.status         = id3tl_pkg::ST_TAG;
            end else if (cur.match_progress == id3tl_pkg::MATCH_I &&
                         data_byte == id3tl_pkg::CHAR_D) begin
               nxt.match_progress = id3tl_pkg::MATCH_ID;
            end else if (data_byte == id3tl_pkg::CHAR_I) begin
               nxt.match_progress = id3tl_pkg::MATCH_I;
            end else begin
               nxt.match_progress = id3tl_pkg::MATCH_NONE;
            end
            if (end_of_stream) begin
               nxt.phase          = id3tl_pkg::PH_ENDED;
               nxt.tag_size       = '0;
               nxt.match_progress = id3tl_pkg::MATCH_NONE;
               res.status         = id3tl_pkg::ST_NOTFOUND;
               res.out_byte       = '0;
            end
         end
         id3tl_pkg::PH_HEADER: begin
            res.out_byte    = data_byte;
            res.status      = id3tl_pkg::ST_TAG;
            nxt.bytes_taken = taken_inc;
            nxt.tag_size    = size_hdr;
            if (taken_inc >= id3tl_pkg::HDR_LEN) begin
               nxt.tag_size = size_total;
               if (taken_inc >= size_total) begin
                  nxt.phase  = id3tl_pkg::PH_DONE;
                  res.status = id3tl_pkg::ST_LAST;
               end else if (end_of_stream) begin
                  nxt.phase  = id3tl_pkg::PH_ENDED;
                  res.status = id3tl_pkg::ST_TRUNC;
               end else begin
                  nxt.phase  = id3tl_pkg::PH_COLLECT;
               end
            end else if (end_of_stream) begin
               nxt.phase    = id3tl_pkg::PH_ENDED;
               nxt.tag_size = '0;
               res.status   = id3tl_pkg::ST_NOTFOUND;
               res.out_byte = '0;
            end
         end
         id3tl_pkg::PH_COLLECT: begin
            res.out_byte    = data_byte;
            res.status      = id3tl_pkg::ST_TAG;
            nxt.bytes_taken = taken_inc;
            if (taken_inc >= cur.tag_size) begin
               nxt.phase  = id3tl_pkg::PH_DONE;
               res.status = id3tl_pkg::ST_LAST;
            end else if (end_of_stream) begin
               nxt.phase  = id3tl_pkg::PH_ENDED;
               res.status = id3tl_pkg::ST_TRUNC;
            end
         end
         default: begin
            res.out_byte = '0;
            res.status   = id3tl_pkg::ST_IGNORED;
         end
      endcase
      res.tag_total_size = (nxt.phase == id3tl_pkg::PH_HEADER ||
                            nxt.phase == id3tl_pkg::PH_SEARCH) ? '0 : nxt.tag_size;
   end

endmodule

// ===== hdl/id3v2_tag_locator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3v2 tag locator
// Scans a byte stream for an ID3v2 tag header and marks the tag's bytes.
// ----------------------------------------------------------------------------
// The req_ch channel carries one stream byte per transfer together with an
// end-of-stream flag on the final byte. For every input transfer the block
// delivers exactly one result transfer on rsp_ch: the byte, its status and
// the total tag size once the ten-byte header has been read.
// The byte is classified by a single layer of logic from the tracker state
// and written into the result register; a result appears in the cycle after
// its input transfer. One byte is taken every cycle while the receiver keeps
// up; the result register holds a waiting result and the block still takes
// a new byte in the same cycle that the waiting result is transferred.
// When the receiver stalls, the result register holds its value and req_ch
// ready drops until the result is taken.
// A synchronous reset returns the tracker to the search for the identifier
// and empties the result register. After a tag completes or the stream
// ends, every further byte is reported as ignored until the next reset.
// ----------------------------------------------------------------------------
module id3v2_tag_locator (
   input  logic               clock,
   input  logic               reset,
   id3tl_req_if.sink          req_ch,
   id3tl_rsp_if.source        rsp_ch
);

   id3tl_pkg::tracker_type state_ff;
   id3tl_pkg::tracker_type state_in;
   id3tl_pkg::result_type  result_ff;
   id3tl_pkg::result_type  result_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   req_take;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;

   id3tl_step u_step (
      .cur           (state_ff),
      .data_byte     (req_ch.data_byte),
      .end_of_stream (req_ch.end_of_stream),
      .nxt           (state_in),
      .res           (result_in)
   );

   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= id3tl_pkg::PH_SEARCH;
         state_ff.match_progress <= id3tl_pkg::MATCH_NONE;
         state_ff.tag_size       <= '0;
         state_ff.bytes_taken    <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_byte       = result_ff.out_byte;
   assign rsp_ch.status         = result_ff.status;
   assign rsp_ch.tag_total_size = result_ff.tag_total_size;

   // A final status is only reported once the tracker has left the tag.
   a_final_status_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (result_ff.status == id3tl_pkg::ST_LAST ||
                        result_ff.status == id3tl_pkg::ST_TRUNC ||
                        result_ff.status == id3tl_pkg::ST_NOTFOUND))
      |-> (state_ff.phase == id3tl_pkg::PH_DONE || state_ff.phase == id3tl_pkg::PH_ENDED))
      else $error("final status reported while the tracker is still active");

   // The header count stays between the identifier and the header length.
   a_header_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == id3tl_pkg::PH_HEADER)
      |-> (state_ff.bytes_taken >= id3tl_pkg::ID_LEN &&
           state_ff.bytes_taken < id3tl_pkg::HDR_LEN))
      else $error("header byte count out of range");

   // No tag bytes are counted while searching.
   a_search_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == id3tl_pkg::PH_SEARCH) |-> (state_ff.bytes_taken == '0))
      else $error("tag bytes counted during the search");

   // A transfer on the input always leaves a result waiting on the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("input transfer produced no result");

endmodule

// ===== tb/sv/tb_id3v2_tag_locator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3v2 tag locator testbench
// Feeds one media stream through the locator: search noise with partial
// identifiers, an identifier split after a stray 'I', a ten-byte header, a
// long tag body and a random ending, then ignored bytes. Each byte's result
// is predicted and compared field by field, with random sender gaps, a
// receiver stall pattern and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_id3v2_tag_locator;

   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 300;

   logic clock;
   logic reset;

   id3tl_req_if req_ch ();
   id3tl_rsp_if rsp_ch ();

   id3v2_tag_locator u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predicted tracker state.
   logic [id3tl_pkg::PHASE_W-1:0] scan_phase  = id3tl_pkg::PH_SEARCH;
   logic [id3tl_pkg::MATCH_W-1:0] track_match = id3tl_pkg::MATCH_NONE;
   logic [id3tl_pkg::SIZE_W-1:0]  track_size  = '0;
   logic [id3tl_pkg::SIZE_W-1:0]  track_taken = '0;

   id3tl_pkg::result_type expected_results[$];
   id3tl_pkg::result_type oldest_result;

   int error_count     = 0;
   int bytes_sent      = 0;
   int results_checked = 0;
   int cycle_count     = 0;
   int burst_left      = 0;
   int stall_tick      = 0;
   int stall_mode      = 0;
   int hold_left       = 0;
   bit hold_request    = 1'b0;
   bit hold_started    = 1'b0;

   int    body_len;
   int    end_mode;
   int    trunc_at;
   string end_name;

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results still expected", cycle_count,
                  expected_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic id3tl_pkg::result_type classify_byte(
      input logic [id3tl_pkg::BYTE_W-1:0] value,
      input logic                         last);
      id3tl_pkg::result_type r;
      r.out_byte       = '0;
      r.status         = id3tl_pkg::ST_IGNORED;
      r.tag_total_size = '0;
      case (scan_phase)
         id3tl_pkg::PH_SEARCH: begin
            r.out_byte = value;
            r.status   = id3tl_pkg::ST_SEARCH;
            if (track_match == id3tl_pkg::MATCH_ID && value == id3tl_pkg::CHAR_THREE) begin
               track_match = id3tl_pkg::MATCH_NONE;
               track_size  = '0;
               track_taken = id3tl_pkg::ID_LEN;
               scan_phase  = id3tl_pkg::PH_HEADER;
               r.status    = id3tl_pkg::ST_TAG;
            end else if (track_match == id3tl_pkg::MATCH_I && value == id3tl_pkg::CHAR_D) begin
               track_match = id3tl_pkg::MATCH_ID;
            end else if (value == id3tl_pkg::CHAR_I) begin
               track_match = id3tl_pkg::MATCH_I;
            end else begin
               track_match = id3tl_pkg::MATCH_NONE;
            end
            if (last) begin
               scan_phase  = id3tl_pkg::PH_ENDED;
               track_size  = '0;
               track_match = id3tl_pkg::MATCH_NONE;
               r.status    = id3tl_pkg::ST_NOTFOUND;
               r.out_byte  = '0;
            end
         end
         id3tl_pkg::PH_HEADER: begin
            r.out_byte = value;
            r.status   = id3tl_pkg::ST_TAG;
            if (track_taken >= id3tl_pkg::SIZE_FIRST)
               track_size = (track_size << id3tl_pkg::SYNCSAFE_W) |
                            (id3tl_pkg::SIZE_W)'(value[id3tl_pkg::SYNCSAFE_W-1:0]);
            track_taken = track_taken + 1'b1;
            if (track_taken >= id3tl_pkg::HDR_LEN) begin
               track_size = track_size + id3tl_pkg::HDR_LEN;
               if (track_taken >= track_size) begin
                  scan_phase = id3tl_pkg::PH_DONE;
                  r.status   = id3tl_pkg::ST_LAST;
               end else if (last) begin
                  scan_phase = id3tl_pkg::PH_ENDED;
                  r.status   = id3tl_pkg::ST_TRUNC;
               end else begin
                  scan_phase = id3tl_pkg::PH_COLLECT;
               end
            end else if (last) begin
               scan_phase = id3tl_pkg::PH_ENDED;
               track_size = '0;
               r.status   = id3tl_pkg::ST_NOTFOUND;
               r.out_byte = '0;
            end
         end
         id3tl_pkg::PH_COLLECT: begin
            r.out_byte  = value;
            r.status    = id3tl_pkg::ST_TAG;
            track_taken = track_taken + 1'b1;
            if (track_taken >= track_size) begin
               scan_phase = id3tl_pkg::PH_DONE;
               r.status   = id3tl_pkg::ST_LAST;
            end else if (last) begin
               scan_phase = id3tl_pkg::PH_ENDED;
               r.status   = id3tl_pkg::ST_TRUNC;
            end
         end
         default: begin
            r.status   = id3tl_pkg::ST_IGNORED;
            r.out_byte = '0;
         end
      endcase
      r.tag_total_size = (scan_phase == id3tl_pkg::PH_HEADER ||
                          scan_phase == id3tl_pkg::PH_SEARCH) ? '0 : track_size;
      return r;
   endfunction

   task automatic send_byte(input logic [id3tl_pkg::BYTE_W-1:0] value, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid         <= 1'b1;
      req_ch.data_byte     <= value;
      req_ch.end_of_stream <= last;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      expected_results.push_back(classify_byte(value, last));
      bytes_sent++;
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         error_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   // Long receiver hold-off, started once by the body test.
   always @(posedge clock) begin
      if (hold_request && !hold_started) begin
         hold_started = 1'b1;
         hold_left    = HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left--;
      end
   end

   // Result checker and receiver stall pattern.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $error("Unexpected result transfer: out_byte %0d status %0d", rsp_ch.out_byte,
                   rsp_ch.status);
         end else begin
            oldest_result = expected_results.pop_front();
            check_field("out_byte", 32'(oldest_result.out_byte), 32'(rsp_ch.out_byte));
            check_field("status", 32'(oldest_result.status), 32'(rsp_ch.status));
            check_field("tag_total_size", 32'(oldest_result.tag_total_size),
                        32'(rsp_ch.tag_total_size));
            results_checked++;
         end
      end
      stall_tick++;
      if (stall_tick % 32 == 0)
         stall_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= (stall_tick % 4 != 0);
            2: rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic test_search_noise();
      logic [id3tl_pkg::BYTE_W-1:0] probe [0:21] = '{
         8'h00, 8'hFF, id3tl_pkg::CHAR_I, 8'h78, id3tl_pkg::CHAR_I, id3tl_pkg::CHAR_D,
         8'h78, id3tl_pkg::CHAR_I, id3tl_pkg::CHAR_I, id3tl_pkg::CHAR_D, id3tl_pkg::CHAR_D,
         id3tl_pkg::CHAR_I, id3tl_pkg::CHAR_D, id3tl_pkg::CHAR_I, id3tl_pkg::CHAR_THREE,
         8'h69, 8'h64, id3tl_pkg::CHAR_THREE, 8'h80, 8'h7F, 8'h01, 8'hFE};
      logic [id3tl_pkg::BYTE_W-1:0] value;
      int pick;
      foreach (probe[i])
         send_byte(probe[i], 1'b0);
      for (int i = 0; i < 150; i++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)
            value = id3tl_pkg::CHAR_I;
         else if (pick == 1)
            value = id3tl_pkg::CHAR_D;
         else if (pick == 2)
            value = id3tl_pkg::CHAR_THREE;
         else
            value = (id3tl_pkg::BYTE_W)'($urandom_range(0, 255));
         // Keep the identifier out of the noise.
         if (track_match == id3tl_pkg::MATCH_ID && value == id3tl_pkg::CHAR_THREE)
            value = 8'h2E;
         send_byte(value, 1'b0);
      end
   endtask

   task automatic test_split_identifier();
      send_byte(id3tl_pkg::CHAR_I, 1'b0);
      send_byte(id3tl_pkg::CHAR_I, 1'b0);
      send_byte(id3tl_pkg::CHAR_D, 1'b0);
      send_byte(id3tl_pkg::CHAR_THREE, 1'b0);
   endtask

   task automatic test_header();
      logic [id3tl_pkg::SIZE_W-1:0] size_field;
      size_field = (id3tl_pkg::SIZE_W)'(body_len);
      send_byte(8'h04, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      // Bit 7 of each size byte must be dropped by the syncsafe decode.
      send_byte({1'($urandom_range(0, 1)), size_field[27:21]}, 1'b0);
      send_byte({1'($urandom_range(0, 1)), size_field[20:14]}, 1'b0);
      send_byte({1'($urandom_range(0, 1)), size_field[13:7]}, 1'b0);
      send_byte({1'($urandom_range(0, 1)), size_field[6:0]}, 1'b0);
   endtask

   task automatic test_body_under_hold_off();
      logic [id3tl_pkg::BYTE_W-1:0] value;
      logic                         last;
      int                           pick;
      for (int i = 0; i < body_len; i++) begin
         if (i == 100) begin
            hold_request = 1'b1;
            burst_left   = 80;
         end
         pick = $urandom_range(0, 7);
         if (pick == 0)
            value = id3tl_pkg::CHAR_I;
         else if (pick == 1)
            value = id3tl_pkg::CHAR_D;
         else if (pick == 2)
            value = id3tl_pkg::CHAR_THREE;
         else
            value = (id3tl_pkg::BYTE_W)'($urandom_range(0, 255));
         last = (end_mode == 2 && i == trunc_at) ||
                (end_mode == 1 && i == body_len - 1);
         send_byte(value, last);
         if (end_mode == 2 && i == trunc_at)
            break;
      end
   endtask

   task automatic test_ignored_tail();
      for (int i = 0; i < 80; i++)
         send_byte((id3tl_pkg::BYTE_W)'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.data_byte     <= '0;
      req_ch.end_of_stream <= 1'b0;
      body_len = $urandom_range(820, 940);
      end_mode = $urandom_range(0, 2);
      trunc_at = body_len - $urandom_range(2, 20);
      end_name = (end_mode == 0) ? "tag complete" :
                 (end_mode == 1) ? "tag complete on the final stream byte" :
                                   "stream ended inside the tag body";
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_search_noise();
      test_split_identifier();
      test_header();
      test_body_under_hold_off();
      test_ignored_tail();

      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d stream bytes and checked %0d results: search noise, split", bytes_sent,
               results_checked);
      $display("identifier, header, %0d-byte body under a long hold-off, ending: %s",
               body_len, end_name);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
